### hw/rtl/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths, reset values, register map and position scaling for the
// servo pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package spp_pkg;

  localparam int CHAN_W  = 4;
  localparam int POS_W   = 16;
  localparam int TIME_W  = 14;
  localparam int FRAME_W = 18;
  localparam int HIGH_W  = 16;
  localparam int RELOAD_W = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [TIME_W-1:0]  SERVO_TIME_RST  = TIME_W'(7500);
  localparam logic [FRAME_W-1:0] FRAME_LEFT_RST  = FRAME_W'(1000);
  localparam logic [FRAME_W-1:0] FRAME_LEN_RST   = FRAME_W'(200000);
  localparam logic [HIGH_W-1:0]  CLK_HIGH_RST    = HIGH_W'(7500);

  localparam int POS_SCALE  = 10000;
  localparam int POS_OFFSET = 2500;
  localparam int PROD_W     = 30;

  typedef enum logic [1:0] {
    REG_PINS_INV  = 2'd0,
    REG_FRAME_LEN = 2'd1,
    REG_CLK_HIGH  = 2'd2
  } reg_idx_t;

  // position * 10000 / 65535 + 2500, exact
  // x = q*65536 + lo  ->  x - q*65535 = lo + q, which stays below 2*65535
  function automatic logic [TIME_W-1:0] scale_position(input logic [POS_W-1:0] pos);
    logic [PROD_W-1:0] prod;
    logic [TIME_W-1:0] q_est;
    logic [16:0]       rem;
    logic [TIME_W-1:0] q;
    prod  = PROD_W'(pos) * PROD_W'(POS_SCALE);
    q_est = prod[PROD_W-1:16];
    rem   = {1'b0, prod[15:0]} + 17'(q_est);
    q     = (rem >= 17'd65535) ? q_est + TIME_W'(1) : q_est;
    return q + TIME_W'(POS_OFFSET);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/servo_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// servo_pulse_sequencer
// Drives clock and reset of an external decade counter, one servo pulse per
// channel in turn, and stores scaled servo positions.
// ----------------------------------------------------------------------------
// Usage:
//   in_* beats are either a set-position (op=1) or a timer compare event (op=0).
//   Each accepted beat gives exactly one out_* beat: pin levels after optional
//   inversion, plus the next compare reload for timer events.
//   A beat accepted into the input register moves on to the result register
//   and shows on out_*. Throughput is one beat per cycle while out_stall is
//   low; the state update and the position scaling are combinational.
//   When out_stall is high the result register holds and one more beat is
//   taken into the input register, after which in_stall rises.
//   Reset (rst_n low, synchronous) puts the sequencer in the reset-high phase
//   with 1000 units of frame time left, all channels at 7500 and the
//   registers at their defaults: no inversion, frame 200000, clock high 7500.
//   The user must write registers over the APB port while the block is idle; it never checks.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pulse_sequencer #(
  parameter int CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [spp_pkg::CHAN_W-1:0]    in_channel,
  input  logic [spp_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_clock_pin,
  output logic                          out_reset_pin,
  output logic                          out_reload_write,
  output logic [spp_pkg::RELOAD_W-1:0]  out_reload_value,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spp_pkg::ADDR_W-1:0]    paddr,
  input  logic [spp_pkg::DATA_W-1:0]    pwdata,
  output logic [spp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import spp_pkg::*;

  localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CHAN_W:0] CH_CNT = (CHAN_W+1)'(CHANNELS);

  typedef enum logic [2:0] {
    PH_CLK_HIGH = 3'd0,
    PH_CLK_LOW  = 3'd1,
    PH_RST_HIGH = 3'd3,
    PH_RST_LOW  = 3'd4
  } phase_t;

  // configuration
  logic               pins_inv_r;
  logic [FRAME_W-1:0] frame_len_r;
  logic [HIGH_W-1:0]  clk_high_r;

  // sequencer state
  phase_t             phase_r, phase_nxt;
  logic [CHAN_W-1:0]  servo_idx_r, servo_idx_nxt;
  logic [FRAME_W-1:0] frame_left_r, frame_left_nxt;
  logic               clk_lvl_r, clk_lvl_nxt;
  logic               rst_lvl_r, rst_lvl_nxt;
  logic [TIME_W-1:0]  servo_times_r [CHANNELS];

  // input and result registers
  logic               in_vld_r;
  logic               in_op_r;
  logic [CHAN_W-1:0]  in_ch_r;
  logic [POS_W-1:0]   in_pos_r;
  logic               out_vld_r;
  logic               out_clk_r, out_rst_r, out_rw_r;
  logic [RELOAD_W-1:0] out_rv_r;

  logic               adv, fire, in_acc, cfg_wr;
  logic               idx_ok, ch_ok, pos_wr;
  logic [TIME_W-1:0]  servo_t, scaled;
  logic               rw;
  logic [RELOAD_W-1:0] rv;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign fire     = in_vld_r && adv;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  assign idx_ok  = {1'b0, servo_idx_r} < CH_CNT;
  assign ch_ok   = {1'b0, in_ch_r} < CH_CNT;
  assign servo_t = idx_ok ? servo_times_r[servo_idx_r[IDXW-1:0]] : '0;
  assign scaled  = scale_position(in_pos_r);
  assign pos_wr  = fire && in_op_r && ch_ok;

  always_comb begin
    phase_nxt      = phase_r;
    servo_idx_nxt  = servo_idx_r;
    frame_left_nxt = frame_left_r;
    clk_lvl_nxt    = clk_lvl_r;
    rst_lvl_nxt    = rst_lvl_r;
    rw             = 1'b0;
    rv             = '0;
    if (!in_op_r) begin
      rw = 1'b1;
      unique case (phase_r)
        PH_CLK_HIGH: begin
          clk_lvl_nxt    = 1'b0;
          rv             = RELOAD_W'(servo_t >> 1);
          frame_left_nxt = (frame_left_r > FRAME_W'(servo_t)) ?
                           frame_left_r - FRAME_W'(servo_t) : '0;
          servo_idx_nxt  = servo_idx_r + CHAN_W'(1);
          phase_nxt      = PH_CLK_LOW;
        end
        PH_CLK_LOW: begin
          if (idx_ok) begin
            clk_lvl_nxt = 1'b1;
            rv          = RELOAD_W'(clk_high_r >> 1);
            phase_nxt   = PH_CLK_HIGH;
          end else begin
            rst_lvl_nxt = 1'b1;
            rv          = RELOAD_W'(frame_left_r >> 2);
            phase_nxt   = PH_RST_HIGH;
          end
        end
        PH_RST_HIGH: begin
          rst_lvl_nxt = 1'b0;
          rv          = RELOAD_W'(frame_left_r >> 2);
          phase_nxt   = PH_RST_LOW;
        end
        default: begin
          // reset-low and any stray code restart the frame
          clk_lvl_nxt    = 1'b1;
          frame_left_nxt = frame_len_r;
          servo_idx_nxt  = '0;
          rv             = RELOAD_W'(clk_high_r >> 1);
          phase_nxt      = PH_CLK_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_inv_r   <= 1'b0;
      frame_len_r  <= FRAME_LEN_RST;
      clk_high_r   <= CLK_HIGH_RST;
      phase_r      <= PH_RST_HIGH;
      servo_idx_r  <= '0;
      frame_left_r <= FRAME_LEFT_RST;
      clk_lvl_r    <= 1'b0;
      rst_lvl_r    <= 1'b1;
      for (int i = 0; i < CHANNELS; i++) begin
        servo_times_r[i] <= SERVO_TIME_RST;
      end
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_PINS_INV:  pins_inv_r  <= pwdata[0];
          REG_FRAME_LEN: frame_len_r <= pwdata[FRAME_W-1:0];
          REG_CLK_HIGH:  clk_high_r  <= pwdata[HIGH_W-1:0];
          default: ;
        endcase
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
      end
      // payload registers, no reset value
      if (in_acc) begin
        in_op_r  <= in_op;
        in_ch_r  <= in_channel;
        in_pos_r <= in_position;
      end
      if (fire) begin
        phase_r      <= phase_nxt;
        servo_idx_r  <= servo_idx_nxt;
        frame_left_r <= frame_left_nxt;
        clk_lvl_r    <= clk_lvl_nxt;
        rst_lvl_r    <= rst_lvl_nxt;
        out_clk_r    <= clk_lvl_nxt ^ pins_inv_r;
        out_rst_r    <= rst_lvl_nxt ^ pins_inv_r;
        out_rw_r     <= rw;
        out_rv_r     <= rv;
      end
      if (pos_wr) begin
        servo_times_r[in_ch_r[IDXW-1:0]] <= scaled;
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PINS_INV:  prdata = DATA_W'(pins_inv_r);
      REG_FRAME_LEN: prdata = DATA_W'(frame_len_r);
      REG_CLK_HIGH:  prdata = DATA_W'(clk_high_r);
      default:       prdata = '0;
    endcase
  end

  assign out_valid        = out_vld_r;
  assign out_clock_pin    = out_clk_r;
  assign out_reset_pin    = out_rst_r;
  assign out_reload_write = out_rw_r;
  assign out_reload_value = out_rv_r;

endmodule

`default_nettype wire

### bench/servo_pulse_sequencer_test.sv
// ----------------------------------------------------------------------------
// servo_pulse_sequencer_test
// Self-checking bench for the servo pulse sequencer. A behavioral copy of the
// phase machine predicts pin levels and compare reloads for every input beat.
// Results are checked in order against that prediction. Traffic runs under
// several register settings, including the extremes, with random idling on
// both channels and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module servo_pulse_sequencer_test;
  import spp_pkg::*;

  localparam int NUM_SERVOS     = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_SET_POS = 1'b1;

  typedef enum logic [2:0] {
    PH_CLOCK_LOW   = 3'd0,
    PH_NEXT_SERVO  = 3'd1,
    PH_RESET_LOW   = 3'd3,
    PH_FRAME_START = 3'd4
  } seq_phase_e;

  typedef struct packed {
    logic                clock_pin;
    logic                reset_pin;
    logic                reload_write;
    logic [RELOAD_W-1:0] reload_value;
  } pin_step_t;

  logic                clk;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic                in_op       = 1'b0;
  logic [CHAN_W-1:0]   in_channel  = '0;
  logic [POS_W-1:0]    in_position = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic                out_clock_pin;
  logic                out_reset_pin;
  logic                out_reload_write;
  logic [RELOAD_W-1:0] out_reload_value;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ADDR_W-1:0]   paddr       = '0;
  logic [DATA_W-1:0]   pwdata      = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predicted sequencer state and register copies
  logic               cfg_invert = 1'b0;
  logic [FRAME_W-1:0] cfg_frame  = FRAME_W'(200000);
  logic [HIGH_W-1:0]  cfg_high   = HIGH_W'(7500);
  seq_phase_e         phase      = PH_RESET_LOW;
  logic [CHAN_W-1:0]  servo_idx  = '0;
  logic [FRAME_W-1:0] frame_left = FRAME_W'(1000);
  logic [TIME_W-1:0]  pulse_time [NUM_SERVOS] = '{default: TIME_W'(7500)};
  logic               clk_level  = 1'b0;
  logic               rst_level  = 1'b1;

  pin_step_t expected_steps [$];
  int        mismatch_count = 0;
  int        idle_cycles    = 0;
  int        stall_left     = 0;
  bit        allow_gaps     = 1'b1;

  servo_pulse_sequencer #(
    .CHANNELS(NUM_SERVOS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_channel      (in_channel),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_clock_pin   (out_clock_pin),
    .out_reset_pin   (out_reset_pin),
    .out_reload_write(out_reload_write),
    .out_reload_value(out_reload_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic pin_step_t advance_sequencer(input logic op,
                                                  input logic [CHAN_W-1:0] ch,
                                                  input logic [POS_W-1:0] pos);
    pin_step_t   step;
    logic [TIME_W-1:0] pulse;
    int unsigned scaled;
    step = '0;
    if (op == OP_SET_POS) begin
      if (ch < NUM_SERVOS) begin
        scaled = (32'(pos) * 32'd10000) / 32'd65535 + 32'd2500;
        pulse_time[ch[2:0]] = TIME_W'(scaled);
      end
    end else begin
      step.reload_write = 1'b1;
      case (phase)
        PH_CLOCK_LOW: begin
          pulse = (servo_idx < NUM_SERVOS) ? pulse_time[servo_idx[2:0]] : '0;
          clk_level = 1'b0;
          step.reload_value = RELOAD_W'(pulse >> 1);
          // remaining frame time saturates at zero
          frame_left = (frame_left > FRAME_W'(pulse)) ? frame_left - FRAME_W'(pulse) : '0;
          servo_idx = servo_idx + 1'b1;
          phase = PH_NEXT_SERVO;
        end
        PH_NEXT_SERVO: begin
          if (servo_idx < NUM_SERVOS) begin
            clk_level = 1'b1;
            step.reload_value = RELOAD_W'(cfg_high >> 1);
            phase = PH_CLOCK_LOW;
          end else begin
            rst_level = 1'b1;
            step.reload_value = RELOAD_W'(frame_left >> 2);
            phase = PH_RESET_LOW;
          end
        end
        PH_RESET_LOW: begin
          rst_level = 1'b0;
          step.reload_value = RELOAD_W'(frame_left >> 2);
          phase = PH_FRAME_START;
        end
        default: begin
          clk_level = 1'b1;
          frame_left = cfg_frame;
          servo_idx = '0;
          step.reload_value = RELOAD_W'(cfg_high >> 1);
          phase = PH_CLOCK_LOW;
        end
      endcase
    end
    step.clock_pin = clk_level ^ cfg_invert;
    step.reset_pin = rst_level ^ cfg_invert;
    return step;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_beat(input logic op, input logic [CHAN_W-1:0] ch,
                           input logic [POS_W-1:0] pos);
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_channel  <= ch;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    expected_steps.push_back(advance_sequencer(op, ch, pos));
  endtask

  // always advances at least one clock, so in_valid never toggles twice in a step
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_steps.size() != 0);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PINS_INV:  cfg_invert = value[0];
      REG_FRAME_LEN: cfg_frame  = value[FRAME_W-1:0];
      REG_CLK_HIGH:  cfg_high   = value[HIGH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_settings(input logic inv, input logic [FRAME_W-1:0] frame,
                                  input logic [HIGH_W-1:0] high);
    hold_until_drained();
    write_register(REG_PINS_INV, DATA_W'(inv));
    write_register(REG_FRAME_LEN, DATA_W'(frame));
    write_register(REG_CLK_HIGH, DATA_W'(high));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random_beat(output bit useful);
    logic [CHAN_W-1:0] ch;
    logic [POS_W-1:0]  pos;
    ch = CHAN_W'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       pos = '0;
      1:       pos = '1;
      default: pos = POS_W'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      send_beat(OP_SET_POS, ch, pos);
      useful = (ch < NUM_SERVOS);
    end else begin
      // channel and position are don't-care on a tick but still random
      send_beat(OP_TICK, ch, pos);
      useful = 1'b1;
    end
  endtask

  task automatic run_random_beats(input int count);
    int done;
    bit useful;
    done = 0;
    while (done < count) begin
      send_random_beat(useful);
      if (useful) done++;
      if (allow_gaps && $urandom_range(0, 99) == 0) hold_until_drained();
    end
  endtask

  // positions at the extremes, ignored channels, then one full frame from reset
  task automatic test_directed_frame();
    send_beat(OP_SET_POS, CHAN_W'(0), '0);
    send_beat(OP_SET_POS, CHAN_W'(7), '1);
    send_beat(OP_SET_POS, CHAN_W'(3), POS_W'(32768));
    send_beat(OP_SET_POS, CHAN_W'(8), '0);
    send_beat(OP_SET_POS, CHAN_W'(15), '1);
    repeat (20) send_beat(OP_TICK, '0, '0);
  endtask

  // zero frame forces the remaining time to saturate every step
  task automatic test_register_extremes();
    program_settings(1'b1, '0, '1);
    run_random_beats(60);
    program_settings(1'b0, '1, '0);
    run_random_beats(60);
    program_settings(1'b1, FRAME_W'(30000), HIGH_W'(1));
    run_random_beats(60);
  endtask

  task automatic test_random_settings();
    logic [FRAME_W-1:0] frame;
    logic [HIGH_W-1:0]  high;
    repeat (6) begin
      case ($urandom_range(0, 2))
        0:       frame = FRAME_W'($urandom_range(0, 60000));
        1:       frame = FRAME_W'($urandom_range(0, 262143));
        default: frame = '1;
      endcase
      high = ($urandom_range(0, 3) == 0) ? '1 : HIGH_W'($urandom_range(0, 65535));
      allow_gaps = ($urandom_range(0, 3) != 0);
      program_settings(1'($urandom_range(0, 1)), frame, high);
      run_random_beats(160);
    end
  endtask

  task automatic test_full_rate();
    program_settings(1'b0, FRAME_W'(200000), HIGH_W'(7500));
    allow_gaps = 1'b0;
    run_random_beats(250);
  endtask

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n || !allow_gaps) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    pin_step_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got clock %0b reset %0b write %0b value %0d",
                 $time, out_clock_pin, out_reset_pin, out_reload_write, out_reload_value);
        mismatch_count++;
      end else begin
        want = expected_steps.pop_front();
        check_field("clock_pin", want.clock_pin, out_clock_pin);
        check_field("reset_pin", want.reset_pin, out_reset_pin);
        check_field("reload_write", want.reload_write, out_reload_write);
        check_field("reload_value", want.reload_value, out_reload_value);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_frame();
    test_register_extremes();
    test_random_settings();
    test_full_rate();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
